>>> src/text_line_fill_justify_macros.svh
// Assertion macros used by the line filler datapath.
// Each macro expects signals named clk and rst_n in the enclosing module.
`ifndef TEXT_LINE_FILL_JUSTIFY_MACROS_SVH
`define TEXT_LINE_FILL_JUSTIFY_MACROS_SVH

// Same-cycle implication.
`define TLF_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define TLF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/tlf_pkg.sv
// ----------------------------------------------------------------------------
// tlf_pkg
// Shared types and codes of the greedy line filler and justifier.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tlf_pkg;

    // Opcodes of an input beat.
    localparam logic [1:0] OP_WORD  = 2'd0;
    localparam logic [1:0] OP_FLUSH = 2'd1;
    localparam logic [1:0] OP_PARA  = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] REG_LINE_WIDTH = 2'd0;
    localparam logic [1:0] REG_JUSTIFY    = 2'd1;

    localparam int COL_W       = 7;
    localparam int LINE_W_RST  = 65;
    localparam int DIV_STEPS   = 7;

    // Controller states.
    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_CNT_RD = 7'b0000010,
        ST_CNT_AC = 7'b0000100,
        ST_DIV    = 7'b0001000,
        ST_FIN    = 7'b0010000,
        ST_EM_RD  = 7'b0100000,
        ST_EM_LD  = 7'b1000000
    } tlf_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic cnt_rd;
        logic cnt_ac;
        logic div_step;
        logic fin;
        logic em_rd;
        logic em_ld;
        logic em_wt;
    } tlf_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic launch;
        logic need_count;
        logic cnt_last;
        logic div_last;
        logic out_taken;
        logic em_last;
        logic out_busy;
    } tlf_sts_t;

endpackage

>>> src/tlf_word_if.sv
// ----------------------------------------------------------------------------
// tlf_word_if
// Input channel carrying one word descriptor or paragraph command per beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tlf_word_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic [6:0] word_len;
    logic       starts_upper;
    logic       starts_hyphen;
    logic       ends_sentence_mark;
    logic       ends_joining_hyphen;
    logic [6:0] first_indent;
    logic [6:0] later_indent;

    modport source (
        output valid, opcode, word_len, starts_upper, starts_hyphen,
               ends_sentence_mark, ends_joining_hyphen, first_indent, later_indent,
        input  ready
    );
    modport sink (
        input  valid, opcode, word_len, starts_upper, starts_hyphen,
               ends_sentence_mark, ends_joining_hyphen, first_indent, later_indent,
        output ready
    );
endinterface

>>> src/tlf_slot_if.sv
// ----------------------------------------------------------------------------
// tlf_slot_if
// Output channel carrying one placed word of an emitted line per beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tlf_slot_if;
    logic       valid;
    logic       ready;
    logic [5:0] word_slot;
    logic [6:0] gap_after;
    logic [6:0] indent;
    logic       line_padded;
    logic       last_of_line;
    logic       last_of_paragraph;

    modport source (
        output valid, word_slot, gap_after, indent, line_padded, last_of_line,
               last_of_paragraph,
        input  ready
    );
    modport sink (
        input  valid, word_slot, gap_after, indent, line_padded, last_of_line,
               last_of_paragraph,
        output ready
    );
endinterface

>>> src/tlf_cfg_if.sv
// ----------------------------------------------------------------------------
// tlf_cfg_if
// Configuration write channel: register index and write data per beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tlf_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [6:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> src/tlf_ram.sv
// ----------------------------------------------------------------------------
// tlf_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tlf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> src/tlf_ctl.sv
// ----------------------------------------------------------------------------
// tlf_ctl
// Controller: sequences accept, gap counting, division and line emission.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tlf_ctl
    import tlf_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  tlf_sts_t sts,
    output tlf_cmd_t cmd
);

    tlf_state_t state_reg, state_next;

    assign in_ready = (state_reg == ST_IDLE);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && sts.launch)
                begin
                    state_next = sts.need_count ? ST_CNT_RD : ST_EM_RD;
                end
            end
            ST_CNT_RD: state_next = ST_CNT_AC;
            ST_CNT_AC: state_next = sts.cnt_last ? ST_DIV : ST_CNT_RD;
            ST_DIV:    state_next = sts.div_last ? ST_FIN : ST_DIV;
            ST_FIN:    state_next = ST_EM_RD;
            ST_EM_RD:  state_next = ST_EM_LD;
            ST_EM_LD:
            begin
                // Stay here while the result beat waits; leave when it is taken.
                if (sts.out_taken)
                begin
                    state_next = sts.em_last ? ST_IDLE : ST_EM_RD;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Command decode.
    always_comb
    begin
        cmd          = '0;
        cmd.accept   = (state_reg == ST_IDLE) && in_valid;
        cmd.cnt_rd   = (state_reg == ST_CNT_RD);
        cmd.cnt_ac   = (state_reg == ST_CNT_AC);
        cmd.div_step = (state_reg == ST_DIV);
        cmd.fin      = (state_reg == ST_FIN);
        cmd.em_rd    = (state_reg == ST_EM_RD);
        cmd.em_ld    = (state_reg == ST_EM_LD) && !sts.out_busy;
        cmd.em_wt    = (state_reg == ST_EM_LD);
    end

endmodule

>>> src/tlf_dp.sv
// ----------------------------------------------------------------------------
// tlf_dp
// Datapath: line state, gap store, padding arithmetic and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "text_line_fill_justify_macros.svh"

module tlf_dp
    import tlf_pkg::*;
#(
    parameter int MAX_LINE_WORDS = 64
) (
    input  logic         clk,
    input  logic         rst_n,
    tlf_word_if.sink     word_in,
    tlf_slot_if.source   slot_out,
    tlf_cfg_if.sink      cfg,
    input  tlf_cmd_t     cmd,
    output tlf_sts_t     sts
);

    localparam int AW = $clog2(MAX_LINE_WORDS);
    localparam int WB = $clog2(MAX_LINE_WORDS + 1);

    // Configuration and line state.
    logic [COL_W-1:0] line_width_reg;
    logic             justify_reg;
    logic [7:0]       line_chars_reg, line_chars_next;
    logic [WB-1:0]    line_words_reg, line_words_next;
    logic             prev_mark_reg, prev_mark_next;
    logic             prev_join_reg, prev_join_next;
    logic             odd_reg, odd_next;
    logic             first_reg, first_next;
    logic [COL_W-1:0] ind_first_reg, ind_first_next;
    logic [COL_W-1:0] ind_later_reg, ind_later_next;

    // Emission state.
    logic [WB-1:0]    em_n_reg, em_k_reg, seen_reg;
    logic [WB-1:0]    npick_reg, n1_reg, psize_reg;
    logic [COL_W-1:0] em_ind_reg, share_reg, seff_reg;
    logic [COL_W-1:0] dvd_reg, rem_reg;
    logic [2:0]       div_cnt_reg;
    logic             em_odd_reg, em_closes_reg, em_adjust_reg, em_padded_reg, raise_reg;

    // Result register.
    logic             out_valid_reg;
    logic [5:0]       o_slot_reg;
    logic [COL_W-1:0] o_gap_reg, o_ind_reg;
    logic             o_pad_reg, o_lol_reg, o_lop_reg;

    // Gap store.
    logic             ram_we;
    logic [AW-1:0]    ram_waddr, ram_raddr;
    logic [COL_W-1:0] ram_wdata, ram_rdata;

    tlf_ram #(.WIDTH(COL_W), .DEPTH(MAX_LINE_WORDS)) u_gaps (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Decode of the offered item.
    logic [COL_W-1:0]  cur_ind;
    logic [1:0]        gap_sel;
    logic [9:0]        sum_chars;
    logic signed [9:0] room, spare;
    logic              is_word, has_words, fits, over, flush, launch;

    always_comb
    begin
        cur_ind   = first_reg ? ind_first_reg : ind_later_reg;
        if (word_in.starts_upper && prev_mark_reg)
        begin
            gap_sel = 2'd2;
        end
        else if (prev_join_reg && !word_in.starts_hyphen)
        begin
            gap_sel = 2'd0;
        end
        else
        begin
            gap_sel = 2'd1;
        end
        sum_chars = {2'b00, line_chars_reg} + 10'(gap_sel) + 10'(word_in.word_len);
        room      = $signed(10'(line_width_reg)) - $signed(10'(cur_ind));
        spare     = room - $signed(10'(line_chars_reg));
        is_word   = (word_in.opcode == OP_WORD) && (word_in.word_len != '0);
        has_words = (line_words_reg != '0);
        fits      = (line_words_reg < WB'(MAX_LINE_WORDS)) && ($signed(sum_chars) <= room);
        over      = is_word && has_words && !fits;
        flush     = (word_in.opcode == OP_FLUSH) && has_words;
        launch    = over || flush;
    end

    assign ram_we    = cmd.accept && is_word && has_words;
    assign ram_waddr = AW'(line_words_reg - WB'(1));
    assign ram_wdata = COL_W'(gap_sel);
    assign ram_raddr = AW'(em_k_reg);

    // Line state update on an accepted beat.
    always_comb
    begin
        line_chars_next = line_chars_reg;
        line_words_next = line_words_reg;
        prev_mark_next  = prev_mark_reg;
        prev_join_next  = prev_join_reg;
        odd_next        = odd_reg;
        first_next      = first_reg;
        ind_first_next  = ind_first_reg;
        ind_later_next  = ind_later_reg;
        if (cmd.accept)
        begin
            if (word_in.opcode == OP_PARA)
            begin
                ind_first_next = word_in.first_indent;
                ind_later_next = word_in.later_indent;
                odd_next       = 1'b1;
                first_next     = 1'b1;
            end
            else if (word_in.opcode == OP_FLUSH)
            begin
                line_chars_next = '0;
                line_words_next = '0;
                odd_next        = 1'b1;
                first_next      = 1'b1;
            end
            else if (is_word)
            begin
                prev_mark_next = word_in.ends_sentence_mark;
                prev_join_next = word_in.ends_joining_hyphen;
                if (has_words && fits)
                begin
                    line_chars_next = sum_chars[7:0];
                    line_words_next = line_words_reg + WB'(1);
                end
                else
                begin
                    line_chars_next = 8'(word_in.word_len);
                    line_words_next = WB'(1);
                    if (over)
                    begin
                        odd_next   = !odd_reg;
                        first_next = 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_width_reg <= COL_W'(LINE_W_RST);
            justify_reg    <= 1'b0;
            line_chars_reg <= '0;
            line_words_reg <= '0;
            prev_mark_reg  <= 1'b0;
            prev_join_reg  <= 1'b0;
            odd_reg        <= 1'b1;
            first_reg      <= 1'b1;
            ind_first_reg  <= '0;
            ind_later_reg  <= '0;
        end
        else
        begin
            if (cfg.valid && cfg.index == REG_LINE_WIDTH)
            begin
                line_width_reg <= cfg.data;
            end
            if (cfg.valid && cfg.index == REG_JUSTIFY)
            begin
                justify_reg <= cfg.data[0];
            end
            line_chars_reg <= line_chars_next;
            line_words_reg <= line_words_next;
            prev_mark_reg  <= prev_mark_next;
            prev_join_reg  <= prev_join_next;
            odd_reg        <= odd_next;
            first_reg      <= first_next;
            ind_first_reg  <= ind_first_next;
            ind_later_reg  <= ind_later_next;
        end
    end

    assign cfg.ready = 1'b1;

    // Restoring divider step: spare columns over nonzero gaps.
    logic [COL_W-1:0] rem_shift;
    logic             div_ge;

    always_comb
    begin
        rem_shift = {rem_reg[COL_W-2:0], dvd_reg[COL_W-1]};
        div_ge    = 8'(rem_shift) >= 8'(npick_reg);
    end

    // Final gap of the word being emitted.
    logic [WB-1:0] ng;
    logic          is_gap, in_pick, extra;
    logic [7:0]    gap_out;

    always_comb
    begin
        ng     = em_n_reg - WB'(1);
        is_gap = em_k_reg < ng;
        if (n1_reg == '0)
        begin
            in_pick = (ram_rdata != '0);
        end
        else if (raise_reg)
        begin
            in_pick = (ram_rdata == COL_W'(2));
        end
        else
        begin
            in_pick = (ram_rdata == COL_W'(1));
        end
        if (em_odd_reg)
        begin
            extra = in_pick && (8'(psize_reg - seen_reg - WB'(1)) < 8'(seff_reg));
        end
        else
        begin
            extra = in_pick && (8'(seen_reg) < 8'(seff_reg));
        end
        if (!is_gap)
        begin
            gap_out = '0;
        end
        else if (!em_adjust_reg || ram_rdata == '0)
        begin
            gap_out = 8'(ram_rdata);
        end
        else
        begin
            gap_out = 8'(ram_rdata) + 8'(share_reg)
                    + 8'(raise_reg && ram_rdata == COL_W'(1)) + 8'(extra);
        end
    end

    // Emission, counting and division registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            em_n_reg      <= '0;
            em_k_reg      <= '0;
            seen_reg      <= '0;
            npick_reg     <= '0;
            n1_reg        <= '0;
            psize_reg     <= '0;
            div_cnt_reg   <= '0;
            em_adjust_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.accept && launch)
            begin
                em_n_reg      <= line_words_reg;
                em_k_reg      <= '0;
                seen_reg      <= '0;
                npick_reg     <= '0;
                n1_reg        <= '0;
                div_cnt_reg   <= '0;
                em_adjust_reg <= 1'b0;
            end
            if (cmd.cnt_ac)
            begin
                npick_reg <= npick_reg + WB'(ram_rdata != '0);
                n1_reg    <= n1_reg + WB'(ram_rdata == COL_W'(1));
                em_k_reg  <= sts.cnt_last ? '0 : em_k_reg + WB'(1);
            end
            if (cmd.div_step)
            begin
                div_cnt_reg <= div_cnt_reg + 3'd1;
            end
            if (cmd.fin)
            begin
                em_adjust_reg <= (npick_reg != '0);
                if (n1_reg == '0)
                begin
                    psize_reg <= npick_reg;
                end
                else if (8'(rem_reg) >= 8'(n1_reg))
                begin
                    psize_reg <= npick_reg - n1_reg;
                end
                else
                begin
                    psize_reg <= n1_reg;
                end
            end
            if (cmd.em_ld)
            begin
                out_valid_reg <= 1'b1;
                seen_reg      <= seen_reg + WB'(in_pick && is_gap);
            end
            if (sts.out_taken)
            begin
                out_valid_reg <= 1'b0;
                em_k_reg      <= em_k_reg + WB'(1);
            end
        end
    end

    // Payload registers of the emission.
    always_ff @(posedge clk)
    begin
        if (cmd.accept && launch)
        begin
            em_ind_reg    <= cur_ind;
            em_odd_reg    <= odd_reg;
            em_closes_reg <= flush;
            em_padded_reg <= over && justify_reg && (spare == '0);
            dvd_reg       <= spare[COL_W-1:0];
            rem_reg       <= '0;
        end
        if (cmd.div_step)
        begin
            rem_reg <= div_ge ? COL_W'(rem_shift - COL_W'(npick_reg)) : rem_shift;
            dvd_reg <= {dvd_reg[COL_W-2:0], div_ge};
        end
        if (cmd.fin)
        begin
            em_padded_reg <= (npick_reg != '0);
            share_reg     <= dvd_reg;
            raise_reg     <= (n1_reg != '0) && (8'(rem_reg) >= 8'(n1_reg));
            seff_reg      <= ((n1_reg != '0) && (8'(rem_reg) >= 8'(n1_reg)))
                             ? COL_W'(rem_reg - COL_W'(n1_reg)) : rem_reg;
        end
        if (cmd.em_ld)
        begin
            o_slot_reg <= 6'(em_k_reg);
            o_gap_reg  <= gap_out[COL_W-1:0];
            o_ind_reg  <= (em_k_reg == '0) ? em_ind_reg : '0;
            o_pad_reg  <= em_padded_reg;
            o_lol_reg  <= (em_k_reg == ng);
            o_lop_reg  <= em_closes_reg;
        end
    end

    // Status to the controller.
    always_comb
    begin
        sts            = '0;
        sts.launch     = launch;
        sts.need_count = over && justify_reg && (spare > 0) && (line_words_reg > WB'(1));
        sts.cnt_last   = (em_k_reg == em_n_reg - WB'(2));
        sts.div_last   = (div_cnt_reg == 3'(DIV_STEPS - 1));
        sts.out_taken  = out_valid_reg && slot_out.ready && cmd.em_wt;
        sts.em_last    = (em_k_reg == ng);
        sts.out_busy   = out_valid_reg;
    end

    assign slot_out.valid             = out_valid_reg;
    assign slot_out.word_slot         = o_slot_reg;
    assign slot_out.gap_after         = o_gap_reg;
    assign slot_out.indent            = o_ind_reg;
    assign slot_out.line_padded       = o_pad_reg;
    assign slot_out.last_of_line      = o_lol_reg;
    assign slot_out.last_of_paragraph = o_lop_reg;

    // Checks on the datapath.
    `TLF_ASSERT_IMP(a_slot_in_line, out_valid_reg, em_k_reg < em_n_reg,
        "result slot beyond the held line")
    `TLF_ASSERT_IMP(a_words_bound, 1'b1, line_words_reg <= WB'(MAX_LINE_WORDS),
        "held word count over limit")
    `TLF_ASSERT_IMP(a_last_no_gap, out_valid_reg && o_lol_reg, o_gap_reg == '0,
        "gap after the last word of a line")
    `TLF_ASSERT_IMP(a_no_accept_busy, out_valid_reg, !cmd.accept,
        "item accepted while a line is emitted")
    `TLF_ASSERT_NEXT(a_out_hold, out_valid_reg && !slot_out.ready, out_valid_reg,
        "result beat dropped before it was taken")

endmodule

>>> src/text_line_fill_justify.sv
// ----------------------------------------------------------------------------
// text_line_fill_justify
// Greedy line filler with optional justification of full lines.
// ----------------------------------------------------------------------------
// Channel    Dir  Beat
// word_in    in   opcode, word length, flags and paragraph indents
// slot_out   out  one placed word: slot, gap, indent, line flags
// cfg        in   register index and write data (always ready)
//
// A fitting word, a start paragraph or an ignored item keeps ST_IDLE.
// A line leaves word by word; each result beat is held until it is taken.
// A justified line first counts its gaps in the gap store, then runs the
// restoring divider and a finishing state.
// No item is taken while a line is emitted; a stalled result holds its beat.
// Reset is asynchronous; the gap store needs no clearing.
`timescale 1ns / 1ps

module text_line_fill_justify
    import tlf_pkg::*;
#(
    parameter int MAX_LINE_WORDS = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    tlf_word_if.sink   word_in,
    tlf_slot_if.source slot_out,
    tlf_cfg_if.sink    cfg
);

    tlf_cmd_t cmd;
    tlf_sts_t sts;
    logic     in_ready;

    assign word_in.ready = in_ready;

    tlf_ctl u_ctl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (word_in.valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    tlf_dp #(.MAX_LINE_WORDS(MAX_LINE_WORDS)) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .word_in  (word_in),
        .slot_out (slot_out),
        .cfg      (cfg),
        .cmd      (cmd),
        .sts      (sts)
    );

endmodule
